>>> rtl/cmvp_pkg.sv
package cmvp_pkg;

  // Array size and fixed-point format
  localparam int NODES            = 16;
  localparam int WEIGHT_FRAC_BITS = 12;

  localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int WDEPTH   = NODES * NODES;
  localparam int ADDR_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int VALUE_W  = 16;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int ACC_W    = PROD_W + NODE_W;
  localparam int DRIVE_W  = 32;
  localparam int FIELD_NODE_W = 4;

  localparam logic signed [ACC_W-1:0] DRIVE_MAX = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] DRIVE_MIN = -DRIVE_MAX - ACC_W'(1);

  // Operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SOURCE = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;

  typedef struct packed {
    logic [1:0]                     operation;
    logic [FIELD_NODE_W-1:0]        from_node;
    logic [FIELD_NODE_W-1:0]        to_node;
    logic signed [VALUE_W-1:0]      value;
    logic                           last;
  } req_t;

  typedef struct packed {
    logic [FIELD_NODE_W-1:0]        dest_node;
    logic signed [DRIVE_W-1:0]      drive;
    logic                           final_res;
  } res_t;

  // Store updates decoded from an accepted request
  typedef struct packed {
    logic wr_weight;
    logic fill;
    logic wr_source;
  } store_cmd_t;

  // One multiply-accumulate step issued by the controller
  typedef struct packed {
    logic              issue;
    logic              first;
    logic              last;
    logic              final_dst;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } mac_cmd_t;

  typedef struct packed {
    logic final_out;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } ctl_state_e;

  function automatic logic node_ok(logic [FIELD_NODE_W-1:0] idx);
    return int'(idx) < NODES;
  endfunction

  function automatic logic [ADDR_W-1:0] weight_addr(logic [NODE_W-1:0] from_idx,
                                                    logic [NODE_W-1:0] to_idx);
    return ADDR_W'(ADDR_W'(from_idx) * ADDR_W'(NODES) + ADDR_W'(to_idx));
  endfunction

endpackage

>>> rtl/cmvp_ctrl.sv
module cmvp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  cmvp_pkg::req_t          req_i,
  input  cmvp_pkg::dp_status_t    status_i,
  output cmvp_pkg::store_cmd_t    store_cmd_o,
  output cmvp_pkg::mac_cmd_t      mac_cmd_o
);

  cmvp_pkg::ctl_state_e state_q, state_d;
  logic [cmvp_pkg::NODE_W-1:0] src_q, src_d;
  logic [cmvp_pkg::NODE_W-1:0] dst_q, dst_d;
  logic accept;
  logic src_end, dst_end;

  assign accept  = start && (state_q == cmvp_pkg::ST_IDLE);
  assign src_end = (int'(src_q) == cmvp_pkg::NODES - 1);
  assign dst_end = (int'(dst_q) == cmvp_pkg::NODES - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cmvp_pkg::ST_IDLE: begin
        if (accept && (req_i.operation == cmvp_pkg::OP_SOURCE) && req_i.last) begin
          state_d = cmvp_pkg::ST_MAC;
        end
      end
      cmvp_pkg::ST_MAC: begin
        if (src_end && dst_end) begin
          state_d = cmvp_pkg::ST_DRAIN;
        end
      end
      cmvp_pkg::ST_DRAIN: begin
        if (status_i.final_out) begin
          state_d = cmvp_pkg::ST_IDLE;
        end
      end
      default: state_d = cmvp_pkg::ST_IDLE;
    endcase
  end

  // Advance source index inside, destination index outside
  always_comb begin
    src_d = src_q;
    dst_d = dst_q;
    if (state_q != cmvp_pkg::ST_MAC) begin
      src_d = '0;
      dst_d = '0;
    end else if (src_end) begin
      src_d = '0;
      dst_d = dst_q + cmvp_pkg::NODE_W'(1);
    end else begin
      src_d = src_q + cmvp_pkg::NODE_W'(1);
    end
  end

  // Outputs
  always_comb begin
    busy                  = (state_q != cmvp_pkg::ST_IDLE);
    store_cmd_o.wr_weight = accept && (req_i.operation == cmvp_pkg::OP_WRITE) &&
                            cmvp_pkg::node_ok(req_i.from_node) &&
                            cmvp_pkg::node_ok(req_i.to_node);
    store_cmd_o.fill      = accept && (req_i.operation == cmvp_pkg::OP_FILL);
    store_cmd_o.wr_source = accept && (req_i.operation == cmvp_pkg::OP_SOURCE) &&
                            cmvp_pkg::node_ok(req_i.from_node);
    mac_cmd_o.issue       = (state_q == cmvp_pkg::ST_MAC);
    mac_cmd_o.first       = (src_q == '0);
    mac_cmd_o.last        = src_end;
    mac_cmd_o.final_dst   = dst_end;
    mac_cmd_o.src         = src_q;
    mac_cmd_o.dst         = dst_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmvp_pkg::ST_IDLE;
      src_q   <= '0;
      dst_q   <= '0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
  end

  // Leave the issue phase right after the last step
  a_mac_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmvp_pkg::ST_MAC) && src_end && dst_end |=> (state_q == cmvp_pkg::ST_DRAIN))
    else $error("issue phase did not end after last step");

  // Every run starts at source 0, destination 0
  a_run_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmvp_pkg::ST_MAC) && ($past(state_q) == cmvp_pkg::ST_IDLE)
    |-> (src_q == '0) && (dst_q == '0))
    else $error("run did not start at index zero");

  // Final result only comes out while draining
  a_final_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.final_out |-> (state_q == cmvp_pkg::ST_DRAIN))
    else $error("final result outside drain");

endmodule

>>> rtl/cmvp_datapath.sv
module cmvp_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmvp_pkg::req_t          req_i,
  input  cmvp_pkg::store_cmd_t    store_cmd_i,
  input  cmvp_pkg::mac_cmd_t      mac_cmd_i,
  output cmvp_pkg::dp_status_t    status_o,
  output logic                    res_valid_o,
  output cmvp_pkg::res_t          res_o
);

  localparam int NW = cmvp_pkg::NODE_W;
  localparam int VW = cmvp_pkg::VALUE_W;

  // Weight memory; entries without a valid bit read as the fill value
  logic signed [VW-1:0]         wmem [cmvp_pkg::WDEPTH];
  logic [cmvp_pkg::WDEPTH-1:0]  wvld_q;
  logic signed [VW-1:0]         fill_q;
  logic signed [VW-1:0]         src_mem_q [cmvp_pkg::NODES];

  logic [cmvp_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic [NW-1:0]                wr_src;

  // Stage 1: read data
  logic                         p1_vld_q, p1_first_q, p1_last_q, p1_final_q;
  logic [NW-1:0]                p1_dst_q;
  logic signed [VW-1:0]         w_rd_q, s_rd_q;
  logic                         wv_rd_q;
  logic signed [VW-1:0]         w_eff;

  // Stage 2: product
  logic                         p2_vld_q, p2_first_q, p2_last_q, p2_final_q;
  logic [NW-1:0]                p2_dst_q;
  logic signed [cmvp_pkg::PROD_W-1:0] prod_d, prod_q;

  // Stage 3: accumulator
  logic                         p3_emit_q, p3_final_q;
  logic [NW-1:0]                p3_dst_q;
  logic signed [cmvp_pkg::ACC_W-1:0] acc_d, acc_q;

  // Output register
  logic signed [cmvp_pkg::ACC_W-1:0] shifted, sat;
  logic                         res_valid_q;
  cmvp_pkg::res_t               res_q;

  assign wr_addr = cmvp_pkg::weight_addr(NW'(req_i.from_node), NW'(req_i.to_node));
  assign rd_addr = cmvp_pkg::weight_addr(mac_cmd_i.src, mac_cmd_i.dst);
  assign wr_src  = NW'(req_i.from_node);

  // Write and read the weight memory
  always_ff @(posedge clk_i) begin
    if (store_cmd_i.wr_weight) begin
      wmem[wr_addr] <= req_i.value;
    end
    if (mac_cmd_i.issue) begin
      w_rd_q <= wmem[rd_addr];
      s_rd_q <= src_mem_q[mac_cmd_i.src];
    end
  end

  // Track written entries; a fill drops them all back to the fill value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q  <= '0;
      fill_q  <= '0;
      wv_rd_q <= 1'b0;
    end else begin
      if (store_cmd_i.fill) begin
        wvld_q <= '0;
        fill_q <= req_i.value;
      end else if (store_cmd_i.wr_weight) begin
        wvld_q[wr_addr] <= 1'b1;
      end
      if (mac_cmd_i.issue) begin
        wv_rd_q <= wvld_q[rd_addr];
      end
    end
  end

  // Hold the source vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cmvp_pkg::NODES; i++) begin
        src_mem_q[i] <= '0;
      end
    end else if (store_cmd_i.wr_source) begin
      src_mem_q[wr_src] <= req_i.value;
    end
  end

  assign w_eff  = wv_rd_q ? w_rd_q : fill_q;
  assign prod_d = cmvp_pkg::PROD_W'(w_eff) * cmvp_pkg::PROD_W'(s_rd_q);
  assign acc_d  = p2_first_q ? cmvp_pkg::ACC_W'(prod_q)
                             : acc_q + cmvp_pkg::ACC_W'(prod_q);

  // Scale and saturate the finished sum
  assign shifted = acc_q >>> cmvp_pkg::WEIGHT_FRAC_BITS;
  always_comb begin
    priority if (shifted > cmvp_pkg::DRIVE_MAX) begin
      sat = cmvp_pkg::DRIVE_MAX;
    end else if (shifted < cmvp_pkg::DRIVE_MIN) begin
      sat = cmvp_pkg::DRIVE_MIN;
    end else begin
      sat = shifted;
    end
  end

  // Pipeline control tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_emit_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      p1_vld_q    <= mac_cmd_i.issue;
      p2_vld_q    <= p1_vld_q;
      p3_emit_q   <= p2_vld_q && p2_last_q;
      res_valid_q <= p3_emit_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    p1_first_q <= mac_cmd_i.first;
    p1_last_q  <= mac_cmd_i.last;
    p1_final_q <= mac_cmd_i.final_dst;
    p1_dst_q   <= mac_cmd_i.dst;

    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    p2_final_q <= p1_final_q;
    p2_dst_q   <= p1_dst_q;
    prod_q     <= prod_d;

    p3_final_q <= p2_final_q;
    p3_dst_q   <= p2_dst_q;
    if (p2_vld_q) begin
      acc_q <= acc_d;
    end

    if (p3_emit_q) begin
      res_q.dest_node <= cmvp_pkg::FIELD_NODE_W'(p3_dst_q);
      res_q.drive     <= sat[cmvp_pkg::DRIVE_W-1:0];
      res_q.final_res <= p3_final_q;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign res_o              = res_q;
  assign status_o.final_out = res_valid_q && res_q.final_res;

  // A result leaves in the cycle after its sum is complete
  a_emit_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_emit_q |=> res_valid_q)
    else $error("finished sum not presented");

  // Nothing follows the final result of a run
  a_final_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.final_res |=> !res_valid_q)
    else $error("result after final one");

endmodule

>>> rtl/coupling_matrix_vector_product.sv
// Weight write, weight fill and plain source element leave busy low.
// Source element with last set: busy until the final result of the run is out;
// the single multiply-accumulate unit takes one weight per cycle, so results come
// one per destination node, as one-cycle strobes.
// Reset (rst_ni low, asynchronous) zeroes all weights and source elements at once.
module coupling_matrix_vector_product (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmvp_pkg::req_t    req_i,
  output logic              res_valid_o,
  output cmvp_pkg::res_t    res_o
);

  cmvp_pkg::store_cmd_t store_cmd;
  cmvp_pkg::mac_cmd_t   mac_cmd;
  cmvp_pkg::dp_status_t status;

  cmvp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .status_i    (status),
    .store_cmd_o (store_cmd),
    .mac_cmd_o   (mac_cmd)
  );

  cmvp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .store_cmd_i (store_cmd),
    .mac_cmd_i   (mac_cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

>>> tb/tb_coupling_matrix_vector_product.sv
`timescale 1ns / 1ps

module tb_coupling_matrix_vector_product;

  localparam int          RANDOM_ITEMS  = 350;
  localparam int          CALM_ITEMS    = 60;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 300;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam longint      SAT_HI        = 2147483647;
  localparam longint      SAT_LO        = -SAT_HI - 1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  cmvp_pkg::req_t req_i;
  logic res_valid_o;
  cmvp_pkg::res_t res_o;

  // Shadow copy of both stores, updated on every accepted request
  logic signed [cmvp_pkg::VALUE_W-1:0] weight_shadow [0:cmvp_pkg::NODES*cmvp_pkg::NODES-1];
  logic signed [cmvp_pkg::VALUE_W-1:0] source_shadow [0:cmvp_pkg::NODES-1];
  cmvp_pkg::res_t                      pending_drives [$];

  int error_count    = 0;
  int accepted_count = 0;
  int ignored_count  = 0;
  int product_count  = 0;
  int results_seen   = 0;
  int random_items   = 0;
  bit idle_enabled   = 1'b0;

  coupling_matrix_vector_product u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  function automatic cmvp_pkg::req_t make_req(logic [1:0] op, int from_idx, int to_idx,
                                              logic signed [cmvp_pkg::VALUE_W-1:0] val,
                                              logic is_last);
    cmvp_pkg::req_t r;
    r.operation = op;
    r.from_node = cmvp_pkg::FIELD_NODE_W'(from_idx);
    r.to_node   = cmvp_pkg::FIELD_NODE_W'(to_idx);
    r.value     = val;
    r.last      = is_last;
    return r;
  endfunction

  // Bias toward the ends of the range and toward small magnitudes
  function automatic logic signed [cmvp_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return cmvp_pkg::VALUE_W'($urandom_range(0, 8)) - 16'sd4;
      default: return cmvp_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // Update the shadow stores and queue the drives a product will emit
  task automatic apply_request(input cmvp_pkg::req_t r);
    longint acc;
    longint scaled;
    cmvp_pkg::res_t want;
    accepted_count++;
    case (r.operation)
      cmvp_pkg::OP_WRITE: begin
        if (int'(r.from_node) < cmvp_pkg::NODES && int'(r.to_node) < cmvp_pkg::NODES)
          weight_shadow[int'(r.from_node) * cmvp_pkg::NODES + int'(r.to_node)] = r.value;
      end
      cmvp_pkg::OP_FILL: begin
        foreach (weight_shadow[k]) weight_shadow[k] = r.value;
      end
      cmvp_pkg::OP_SOURCE: begin
        if (int'(r.from_node) < cmvp_pkg::NODES) source_shadow[int'(r.from_node)] = r.value;
        if (r.last) begin
          product_count++;
          for (int d = 0; d < cmvp_pkg::NODES; d++) begin
            acc = 0;
            for (int s = 0; s < cmvp_pkg::NODES; s++)
              acc += longint'(weight_shadow[s * cmvp_pkg::NODES + d]) *
                     longint'(source_shadow[s]);
            scaled = acc >>> cmvp_pkg::WEIGHT_FRAC_BITS;
            if (scaled > SAT_HI) scaled = SAT_HI;
            if (scaled < SAT_LO) scaled = SAT_LO;
            want.dest_node = cmvp_pkg::FIELD_NODE_W'(d);
            want.drive     = cmvp_pkg::DRIVE_W'(scaled);
            want.final_res = (d == cmvp_pkg::NODES - 1);
            pending_drives.push_back(want);
          end
        end
      end
      default: ignored_count++;
    endcase
  endtask

  task automatic check_result(input cmvp_pkg::res_t got);
    cmvp_pkg::res_t want;
    results_seen++;
    if (pending_drives.size() == 0) begin
      report_mismatch($sformatf("unexpected result dest %0d drive %0d",
                                got.dest_node, got.drive));
      return;
    end
    want = pending_drives.pop_front();
    if (got.dest_node !== want.dest_node)
      report_mismatch($sformatf("dest_node got %0d want %0d", got.dest_node, want.dest_node));
    if (got.drive !== want.drive)
      report_mismatch($sformatf("drive of dest %0d got %0d want %0d",
                                want.dest_node, got.drive, want.drive));
    if (got.final_res !== want.final_res)
      report_mismatch($sformatf("final_res of dest %0d got %0b want %0b",
                                want.dest_node, got.final_res, want.final_res));
  endtask

  // Check results first, since a drive at this edge belongs to an older request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) check_result(res_o);
      if (start && !busy) apply_request(req_i);
    end
  end

  // Drive one request, at times idling first when enabled; hold it until accepted
  task automatic send_request(input cmvp_pkg::req_t r);
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start, let the monitor record the last request, then wait for all drives
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_drives.size() != 0) @(posedge clk_i);
  endtask

  // Product straight after reset sees cleared stores
  task automatic test_cleared_stores();
    send_request(make_req(cmvp_pkg::OP_SOURCE, 9, 3, 16'sd1234, 1'b1));
  endtask

  // Unused code and last on writes or fills must start nothing
  task automatic test_ignored_cases();
    send_request(make_req(OP_UNUSED, 15, 15, 16'sh7fff, 1'b1));
    send_request(make_req(cmvp_pkg::OP_WRITE, 15, 0, 16'sh8000, 1'b1));
    send_request(make_req(cmvp_pkg::OP_FILL, 0, 15, 16'sh8000, 1'b1));
    send_request(make_req(OP_UNUSED, 0, 0, 16'sh0000, 1'b0));
  endtask

  // Largest magnitudes in weights and sources, both signs
  task automatic test_extremes();
    send_request(make_req(cmvp_pkg::OP_SOURCE, 0, 0, 16'sh8000, 1'b0));
    send_request(make_req(cmvp_pkg::OP_SOURCE, 15, 0, 16'sh7fff, 1'b0));
    send_request(make_req(cmvp_pkg::OP_SOURCE, 7, 15, 16'sh8000, 1'b1));
    send_request(make_req(cmvp_pkg::OP_FILL, 5, 5, 16'sh7fff, 1'b0));
    send_request(make_req(cmvp_pkg::OP_WRITE, 15, 15, 16'sh8000, 1'b0));
    send_request(make_req(cmvp_pkg::OP_WRITE, 0, 15, 16'sh8000, 1'b0));
    send_request(make_req(cmvp_pkg::OP_SOURCE, 15, 15, 16'sh8000, 1'b1));
  endtask

  // A small negative sum must round toward minus infinity, not toward zero
  task automatic test_floor_rounding();
    send_request(make_req(cmvp_pkg::OP_FILL, 0, 0, 16'sh0000, 1'b0));
    send_request(make_req(cmvp_pkg::OP_WRITE, 2, 7, 16'sd1, 1'b0));
    send_request(make_req(cmvp_pkg::OP_WRITE, 4, 9, -16'sd3, 1'b0));
    send_request(make_req(cmvp_pkg::OP_SOURCE, 4, 0, 16'sd5, 1'b0));
    send_request(make_req(cmvp_pkg::OP_SOURCE, 2, 0, -16'sd1, 1'b1));
  endtask

  // Hold off the next request until every drive has come back
  task automatic test_pause_for_results();
    send_request(make_req(cmvp_pkg::OP_SOURCE, $urandom_range(0, 15), $urandom_range(0, 15),
                          pick_value(), 1'b1));
    wait_for_results();
    send_request(make_req(cmvp_pkg::OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                          pick_value(), 1'b0));
  endtask

  // One load: optional fill, some weights, maybe an unused code, a source vector usually ending in last
  task automatic load_and_multiply();
    int n_writes;
    int n_sources;
    bit drop_last;
    if ($urandom_range(0, 3) == 0) begin
      send_request(make_req(cmvp_pkg::OP_FILL, $urandom_range(0, 15), $urandom_range(0, 15),
                            pick_value(), 1'($urandom)));
      random_items++;
    end
    n_writes = $urandom_range(0, 10);
    for (int i = 0; i < n_writes; i++) begin
      send_request(make_req(cmvp_pkg::OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                            pick_value(), 1'($urandom)));
      random_items++;
    end
    if ($urandom_range(0, 5) == 0)
      send_request(make_req(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                            pick_value(), 1'($urandom)));
    n_sources = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cmvp_pkg::NODES)
                                             : cmvp_pkg::NODES;
    drop_last = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n_sources; i++) begin
      send_request(make_req(cmvp_pkg::OP_SOURCE,
                            (n_sources == cmvp_pkg::NODES) ? i : $urandom_range(0, 15),
                            $urandom_range(0, 15), pick_value(),
                            (i == n_sources - 1) && !drop_last));
      random_items++;
    end
  endtask

  task automatic test_random_sequences();
    while (random_items < RANDOM_ITEMS) begin
      idle_enabled = (random_items < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 2) != 0);
      load_and_multiply();
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    idle_enabled = 1'b0;
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d drives outstanding",
             CYCLE_LIMIT, pending_drives.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    foreach (weight_shadow[k]) weight_shadow[k] = '0;
    foreach (source_shadow[k]) source_shadow[k] = '0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_stores();
    test_ignored_cases();
    test_extremes();
    test_floor_rounding();
    test_pause_for_results();
    idle_enabled = 1'b1;
    test_random_sequences();

    // Drain, then give stray drives time to show up
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d accepted requests (%0d ignored) and %0d products,",
             accepted_count, ignored_count, product_count);
    $display("checking %0d drive results with %0d mismatches.", results_seen, error_count);
    if (error_count == 0 && pending_drives.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
